/* sv/nearest_palette_color_defines.svh */
// ---------------------------------------------------------------------------
// Nearest palette colour search - assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

// same-cycle implication
`define NPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/npc_pkg.sv */
// ---------------------------------------------------------------------------
// Nearest palette colour search - package
// Widths, codes, transaction types and helpers shared by the block.
// ---------------------------------------------------------------------------
package npc_pkg;

    localparam int unsigned COMP_W              = 8;
    localparam int unsigned IDX_W               = 8;
    localparam int unsigned COUNT_W             = 9;
    localparam int unsigned SQ_W                = 2 * COMP_W;
    localparam int unsigned DIST_W              = SQ_W + 2;
    localparam int unsigned DEF_PALETTE_ENTRIES = 256;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] color_index;
        logic             exact_match;
    } t_out_item;

    // one palette entry presented to the distance unit
    typedef struct packed {
        logic             slot;
        logic             active;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] index;
        t_rgb             color;
    } t_probe;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] color_index;
        logic             exact_match;
    } t_result;

    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* sv/npc_cell.sv */
// ---------------------------------------------------------------------------
// Nearest palette colour search - palette cell
// Holds one palette entry; loads it on a write and takes the entry of the next
// cell of the ring while a search rotates the palette.
// ---------------------------------------------------------------------------
module npc_cell
    import npc_pkg::*;
#(
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_index,
    input  t_rgb             i_wr_color,
    input  logic             i_shift,
    input  t_rgb             i_next_color,
    output t_rgb             o_color
);

    t_rgb r_color;
    t_rgb n_color;

    always_comb begin
        n_color = r_color;
        if (i_shift) begin
            n_color = i_next_color;
        end else if (i_wr_en && (i_wr_index == IDX_W'(CELL_INDEX))) begin
            n_color = i_wr_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    assign o_color = r_color;

endmodule

/* sv/npc_dist.sv */
// ---------------------------------------------------------------------------
// Nearest palette colour search - distance and minimum unit
// Four-stage pipeline: absolute differences, squares, sum, running minimum.
// Holds the finished result until taken.
// ---------------------------------------------------------------------------
module npc_dist
    import npc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_probe  i_probe,
    input  t_rgb    i_query,
    input  logic    i_take,
    output t_result o_result
);

    typedef struct packed {
        logic             slot;
        logic             active;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] index;
    } t_tag;

    typedef struct packed {
        logic [COMP_W-1:0] dr;
        logic [COMP_W-1:0] dg;
        logic [COMP_W-1:0] db;
    } t_diff;

    typedef struct packed {
        logic [SQ_W-1:0] sr;
        logic [SQ_W-1:0] sg;
        logic [SQ_W-1:0] sb;
    } t_sq;

    t_tag              r_tag1, r_tag2, r_tag3;
    t_diff             r_diff;
    t_sq               r_sq;
    logic [DIST_W-1:0] r_sum;
    logic              r_found, n_found;
    logic [DIST_W-1:0] r_best_d, n_best_d;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic              r_hold, n_hold;
    t_tag              w_tag0;

    assign w_tag0 = '{slot:   i_probe.slot,
                      active: i_probe.active,
                      first:  i_probe.first,
                      last:   i_probe.last,
                      index:  i_probe.index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.slot <= 1'b0;
            r_tag2.slot <= 1'b0;
            r_tag3.slot <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            r_tag1 <= w_tag0;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff.dr     <= abs_diff(i_probe.color.red,   i_query.red);
        r_diff.dg     <= abs_diff(i_probe.color.green, i_query.green);
        r_diff.db     <= abs_diff(i_probe.color.blue,  i_query.blue);
        r_sq.sr       <= SQ_W'(r_diff.dr) * SQ_W'(r_diff.dr);
        r_sq.sg       <= SQ_W'(r_diff.dg) * SQ_W'(r_diff.dg);
        r_sq.sb       <= SQ_W'(r_diff.db) * SQ_W'(r_diff.db);
        r_sum         <= DIST_W'(r_sq.sr) + DIST_W'(r_sq.sg) + DIST_W'(r_sq.sb);
        r_found       <= n_found;
        r_best_d      <= n_best_d;
        r_best_idx    <= n_best_idx;
    end

    always_comb begin
        n_found    = r_found;
        n_best_d   = r_best_d;
        n_best_idx = r_best_idx;
        n_hold     = r_hold && !i_take;
        if (r_tag3.slot) begin
            if (r_tag3.first) begin
                n_found    = r_tag3.active;
                n_best_d   = r_sum;
                n_best_idx = r_tag3.active ? r_tag3.index : '0;
            end else if (r_tag3.active && (!r_found || (r_sum < r_best_d))) begin
                n_found    = 1'b1;
                n_best_d   = r_sum;
                n_best_idx = r_tag3.index;
            end
            if (r_tag3.last) begin
                n_hold = 1'b1;
            end
        end
    end

    assign o_result = '{valid:       r_hold,
                        color_index: r_best_idx,
                        exact_match: r_found && (r_best_d == '0)};

endmodule

/* sv/nearest_palette_color.sv */
// ---------------------------------------------------------------------------
// Nearest palette colour search - top level
// Palette held in a ring of cells; a query rotates the ring once past a
// pipelined squared-distance and minimum unit.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we               | i_cfg_wdata (palette count)
//
//  A palette write produces no result.
//  A query rotates the ring through all PALETTE_ENTRIES cells, one entry per
//  cycle into the distance unit, then passes the distance pipeline and the
//  result hand-off; no new item is taken until its result has been handed off.
//  Reset clears control state and sets the palette count to 256; palette
//  contents are undefined until written.
//  A stalled result holds the block in its flush state; writes wait meanwhile.
// ---------------------------------------------------------------------------
module nearest_palette_color
    import npc_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_palette_count;
    t_rgb               r_query;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data, n_out_data;

    logic    w_in_acc;
    logic    w_wr_en;
    logic    w_shift;
    logic    w_last;
    logic    w_take;
    t_rgb    w_in_color;
    t_rgb    w_cell_color [PALETTE_ENTRIES];
    t_probe  w_probe;
    t_result w_result;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_wr_en    = w_in_acc && (i_in_data.action == ACTION_WRITE);
    assign w_shift    = (r_state == S_SCAN);
    assign w_last     = (r_cnt == CNT_W'(PALETTE_ENTRIES - 1));
    assign w_in_color = '{red:   i_in_data.red,
                          green: i_in_data.green,
                          blue:  i_in_data.blue};

    genvar k;
    generate
        for (k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
            npc_cell #(
                .CELL_INDEX (k)
            ) u_cell (
                .i_clk        (i_clk),
                .i_wr_en      (w_wr_en),
                .i_wr_index   (i_in_data.entry_index),
                .i_wr_color   (w_in_color),
                .i_shift      (w_shift),
                .i_next_color (w_cell_color[(k + 1) % PALETTE_ENTRIES]),
                .o_color      (w_cell_color[k])
            );
        end
    endgenerate

    assign w_probe = '{slot:   w_shift,
                       active: (COUNT_W'(r_cnt) < r_palette_count),
                       first:  (r_cnt == '0),
                       last:   w_last,
                       index:  IDX_W'(r_cnt),
                       color:  w_cell_color[0]};

    npc_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_probe  (w_probe),
        .i_query  (r_query),
        .i_take   (w_take),
        .o_result (w_result)
    );

    assign w_take = (r_state == S_FLUSH) && w_result.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_in_acc && (i_in_data.action == ACTION_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_take) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{color_index: w_result.color_index,
                                    exact_match: w_result.exact_match};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
            r_palette_count <= COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_palette_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_in_acc) begin
            r_query <= w_in_color;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* sv/npc_checker.sv */
// ---------------------------------------------------------------------------
// Nearest palette colour search - port checker
// Watches the top-level ports over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "nearest_palette_color_defines.svh"

module npc_checker
    import npc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input t_in_item           i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_item          o_out_data,
    input logic               i_cfg_we,
    input logic [COUNT_W-1:0] i_cfg_wdata
);

    logic w_in_acc;
    logic w_query_acc;
    logic w_write_acc;
    logic w_unused;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_query_acc = w_in_acc && (i_in_data.action == ACTION_QUERY);
    assign w_write_acc = w_in_acc && (i_in_data.action == ACTION_WRITE);
    assign w_unused    = i_cfg_we ^ (^i_cfg_wdata);

    `NPC_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_query_acc, o_in_stall)
    `NPC_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, w_write_acc, !o_in_stall)
    `NPC_ASSERT_IMPL(a_result_after_scan, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))
    `NPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `NPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);

/* test/nearest_palette_color_tb.sv */
// ---------------------------------------------------------------------------
// Nearest palette colour search - testbench
// Loads palettes, sets the searched count and issues colour queries, with
// random idling on both channels and one long output hold-off. Typed directed
// queries are checked against fixed expected answers, all others against a
// local nearest-colour search over a shadow copy of the palette.
// ---------------------------------------------------------------------------
module nearest_palette_color_tb;
    import npc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES;
    localparam int IDLE_WAIT       = PALETTE_ENTRIES + 8;
    localparam int HOLD_CYCLES     = 1500;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int PHASE_ITEMS     = 60;

    typedef enum {ROW_CONFIG, ROW_WRITE, ROW_QUERY} t_row_kind;

    typedef struct {
        t_row_kind kind;
        int        arg;
        int        red;
        int        green;
        int        blue;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;

    t_rgb               palette_shadow [PALETTE_ENTRIES];
    logic [COUNT_W-1:0] count_shadow = COUNT_RESET;
    t_out_item          pending_answers [$];
    t_dir_row           dir_rows [$];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    bit                 pressure_req = 1'b0;
    bit                 pressure_done = 1'b0;
    bit                 calm_phase = 1'b0;
    int                 hold_left = 0;
    int                 run_left = 0;

    nearest_palette_color dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            5: return 8'd255;
            default: return COMP_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] c);
        int v;
        v = int'(c) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return COMP_W'(v);
    endfunction

    function automatic int searched_span();
        return (int'(count_shadow) > PALETTE_ENTRIES) ? PALETTE_ENTRIES : int'(count_shadow);
    endfunction

    function automatic t_out_item predict_nearest(input t_rgb q);
        t_out_item ans;
        int        span;
        int        best_d;
        int        d;
        int        dr;
        int        dg;
        int        db;
        ans = '0;
        best_d = 0;
        span = searched_span();
        for (int i = 0; i < span; i++) begin
            dr = int'(palette_shadow[i].red) - int'(q.red);
            dg = int'(palette_shadow[i].green) - int'(q.green);
            db = int'(palette_shadow[i].blue) - int'(q.blue);
            d = dr * dr + dg * dg + db * db;
            if (i == 0 || d < best_d) begin
                best_d = d;
                ans.color_index = IDX_W'(i);
            end
        end
        ans.exact_match = (span > 0) && (best_d == 0);
        return ans;
    endfunction

    function automatic void add_row(input t_row_kind kind, input int arg, input int red,
                                    input int green, input int blue, input bit typed,
                                    input int want_idx, input bit want_exact);
        t_dir_row row;
        row.kind = kind;
        row.arg = arg;
        row.red = red;
        row.green = green;
        row.blue = blue;
        row.typed = typed;
        row.want.color_index = IDX_W'(want_idx);
        row.want.exact_match = want_exact;
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        gap = 0;
        if (!calm_phase && $urandom_range(0, 99) >= 50) gap = pick_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.action == ACTION_WRITE) begin
            palette_shadow[it.entry_index] = '{it.red, it.green, it.blue};
        end else begin
            pending_answers.push_back(typed ? want : predict_nearest('{it.red, it.green, it.blue}));
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_palette_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        count_shadow = value;
    endtask

    // output side: random stall runs, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) i_out_stall <= 1'b0;
        end else if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (calm_phase) begin
            i_out_stall <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
        end else begin
            run_left = pick_len();
            i_out_stall <= ($urandom_range(0, 99) < 35);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result, color_index", o_out_data.color_index, -1);
            end else begin
                want = pending_answers.pop_front();
                if (o_out_data.color_index !== want.color_index)
                    report_mismatch("color_index", o_out_data.color_index, want.color_index);
                if (o_out_data.exact_match !== want.exact_match)
                    report_mismatch("exact_match", o_out_data.exact_match, want.exact_match);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("[nearest_palette_color] ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_in_item           it;
        t_out_item          none;
        int                 order [PALETTE_ENTRIES];
        int                 j;
        int                 tmp;
        int                 span;
        int                 pick;
        logic [COUNT_W-1:0] counts [9];

        none = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(ROW_CONFIG, 0,   0,   0,   0,   0, 0, 0);
        add_row(ROW_QUERY,  0,   0,   0,   0,   1, 0, 0);
        add_row(ROW_QUERY,  255, 255, 255, 255, 1, 0, 0);
        add_row(ROW_WRITE,  0,   0,   0,   0,   0, 0, 0);
        add_row(ROW_WRITE,  1,   255, 255, 255, 0, 0, 0);
        add_row(ROW_WRITE,  2,   255, 0,   0,   0, 0, 0);
        add_row(ROW_WRITE,  3,   0,   255, 0,   0, 0, 0);
        add_row(ROW_WRITE,  4,   0,   0,   255, 0, 0, 0);
        add_row(ROW_WRITE,  5,   0,   0,   0,   0, 0, 0);
        add_row(ROW_CONFIG, 6,   0,   0,   0,   0, 0, 0);
        add_row(ROW_QUERY,  0,   0,   0,   0,   1, 0, 1);
        add_row(ROW_QUERY,  170, 255, 255, 255, 1, 1, 1);
        add_row(ROW_QUERY,  85,  0,   0,   255, 1, 4, 1);
        add_row(ROW_QUERY,  0,   200, 10,  10,  0, 0, 0);
        add_row(ROW_QUERY,  0,   128, 128, 128, 0, 0, 0);
        add_row(ROW_QUERY,  255, 10,  200, 30,  0, 0, 0);
        add_row(ROW_CONFIG, 1,   0,   0,   0,   0, 0, 0);
        add_row(ROW_QUERY,  0,   255, 255, 255, 1, 0, 0);
        add_row(ROW_QUERY,  0,   0,   0,   0,   1, 0, 1);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CONFIG) begin
                write_palette_count(COUNT_W'(dir_rows[k].arg));
            end else begin
                it.action = (dir_rows[k].kind == ROW_WRITE) ? ACTION_WRITE : ACTION_QUERY;
                it.entry_index = IDX_W'(dir_rows[k].arg);
                it.red = COMP_W'(dir_rows[k].red);
                it.green = COMP_W'(dir_rows[k].green);
                it.blue = COMP_W'(dir_rows[k].blue);
                send_item(it, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // fill the whole palette in shuffled order
        for (int i = 0; i < PALETTE_ENTRIES; i++) order[i] = i;
        for (int i = PALETTE_ENTRIES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            it.action = ACTION_WRITE;
            it.entry_index = IDX_W'(order[i]);
            it.red = rand_comp();
            it.green = rand_comp();
            it.blue = rand_comp();
            send_item(it, 1'b0, none);
        end

        counts = '{COUNT_W'(256), COUNT_W'(511), COUNT_W'($urandom_range(1, 8)), COUNT_W'(2),
                   COUNT_W'(255), COUNT_W'(0), COUNT_W'($urandom_range(257, 510)),
                   COUNT_W'(128), COUNT_W'($urandom_range(3, 40))};

        foreach (counts[ph]) begin
            write_palette_count(counts[ph]);
            calm_phase = (ph == 4 || ph == 7);
            span = searched_span();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 10) pressure_req = 1'b1;
                it.red = rand_comp();
                it.green = rand_comp();
                it.blue = rand_comp();
                it.entry_index = IDX_W'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 60) begin
                    it.action = ACTION_WRITE;
                    if (span > 0 && $urandom_range(0, 99) < 80)
                        it.entry_index = IDX_W'($urandom_range(0, span - 1));
                end else begin
                    it.action = ACTION_QUERY;
                    pick = $urandom_range(0, 99);
                    if (span > 0 && pick < 60) begin
                        j = $urandom_range(0, span - 1);
                        it.red = palette_shadow[j].red;
                        it.green = palette_shadow[j].green;
                        it.blue = palette_shadow[j].blue;
                        if (pick >= 35) begin
                            it.red = nudge(it.red);
                            it.green = nudge(it.green);
                            it.blue = nudge(it.blue);
                        end
                    end
                end
                send_item(it, 1'b0, none);
            end
        end

        calm_phase = 1'b0;
        wait_idle();
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("[nearest_palette_color] OK");
        end else begin
            $display("[nearest_palette_color] ERROR");
        end
        $finish;
    end

endmodule

/* nearest_palette_color.f */
+incdir+sv
sv/npc_pkg.sv
sv/npc_cell.sv
sv/npc_dist.sv
sv/nearest_palette_color.sv
sv/npc_checker.sv
test/nearest_palette_color_tb.sv
